/* hdl/pba_pkg.sv */
// Package: shared types, codes and defaults for the pool block allocator.
`default_nettype none
package pba_pkg;
  localparam int MAX_BLOCKS_DEF = 16;
  localparam int ADDR_BITS_DEF  = 32;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_FREE    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic [1:0] CFG_POOL_BASE = 2'd0;
  localparam logic [1:0] CFG_POOL_SIZE = 2'd1;
  localparam logic [1:0] CFG_OVERHEAD  = 2'd2;

  // Result of one list scan step, from the compare unit to the sequencer.
  typedef struct packed {
    logic hit;
  } pba_cmp_t;
endpackage
`default_nettype wire

/* hdl/pba_cmp.sv */
// Shared compare unit: size fit test or address match on one list entry.
`default_nettype none
module pba_cmp #(
  parameter int ADDR_BITS = pba_pkg::ADDR_BITS_DEF
) (
  input  wire logic                 mode_addr,
  input  wire logic [32:0]          entry_size,
  input  wire logic [32:0]          need,
  input  wire logic [ADDR_BITS-1:0] entry_addr,
  input  wire logic [ADDR_BITS-1:0] key_addr,
  output pba_pkg::pba_cmp_t         res
);
  import pba_pkg::*;
  // one compare per cycle, either kind
  always_comb begin
    if (mode_addr) res.hit = (entry_addr == key_addr);
    else           res.hit = (entry_size >= need);
  end
endmodule
`default_nettype wire

/* hdl/pool_block_allocator_top.sv */
// Top level: pool block allocator with busy and freed lists and a bump pointer.
// One item at a time; the list scan steps each entry through SCAN and DECIDE using the
// shared compare unit, and the compaction moves each entry through DECIDE and SHIFT.
// busy is high from acceptance until the result strobe; the receiver cannot stall.
// Reset (synchronous, rst_n low) clears counts, sets bump_top and bytes_left to 0
// and block_overhead to 16; list contents stay undefined until written.
`default_nettype none
module pool_block_allocator_top #(
  parameter int MAX_BLOCKS = pba_pkg::MAX_BLOCKS_DEF,
  parameter int ADDR_BITS  = pba_pkg::ADDR_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_kind,
  input  wire logic [31:0] in_req_size,
  input  wire logic [31:0] in_free_addr,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [31:0]      out_block_addr,
  output logic             out_any_busy,
  output logic [31:0]      out_oldest_busy_addr
);
  import pba_pkg::*;
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int EW = ADDR_BITS + 33;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_SCAN = 6'b000010, S_DECIDE = 6'b000100,
    S_SHIFT = 6'b001000, S_APPEND = 6'b010000, S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [31:0] base_r, psize_r;
  logic [7:0]  ovh_r;
  logic [ADDR_BITS-1:0] top_r;
  logic [31:0] left_r;
  logic [CW-1:0] bcnt_r, fcnt_r;
  logic [1:0]  kind_r;
  logic [32:0] need_r;
  logic [ADDR_BITS-1:0] key_r;
  logic [CW-1:0] idx_r;
  logic found_r;
  logic [EW-1:0] hit_r;
  logic [1:0]  stat_r;
  logic [31:0] baddr_r;
  logic [ADDR_BITS-1:0] oldest_r;

  // list memories: entry = {addr, size}
  logic [EW-1:0] bmem [MAX_BLOCKS];
  logic [EW-1:0] fmem [MAX_BLOCKS];
  logic [EW-1:0] rd_r, rd1_r;

  logic [ADDR_BITS-1:0] key_ext;
  pba_cmp_t cmp;
  logic src_free; // scanning / compacting the freed list
  assign src_free = (kind_r == KIND_ALLOC);
  assign key_ext = ADDR_BITS'(in_free_addr);

  pba_cmp #(.ADDR_BITS(ADDR_BITS)) u_cmp (
    .mode_addr (!src_free),
    .entry_size(rd_r[32:0]),
    .need      (need_r),
    .entry_addr(rd_r[EW-1:33]),
    .key_addr  (key_r),
    .res       (cmp)
  );

  logic [CW-1:0] scnt;
  assign scnt = src_free ? fcnt_r : bcnt_r;
  logic [IW-1:0] ra;
  assign ra = idx_r[IW-1:0];

  // registered reads at the walk index and the one after
  logic [IW-1:0] ra1;
  assign ra1 = IW'(idx_r + CW'(1));
  always_ff @(posedge clk) begin
    rd_r  <= src_free ? fmem[ra] : bmem[ra];
    rd1_r <= src_free ? fmem[ra1] : bmem[ra1];
    oldest_r <= bmem[0][EW-1:33];
  end

  logic [EW-1:0] new_e;
  assign new_e = found_r ? hit_r : {top_r, need_r};

  // list writes: compaction on the source list, append on the destination
  always_ff @(posedge clk) begin
    if (state_r == S_SHIFT && ((idx_r + CW'(1)) < scnt)) begin
      if (src_free) fmem[ra] <= rd1_r;
      else          bmem[ra] <= rd1_r;
    end
    if (state_r == S_APPEND) begin
      if (src_free) begin
        if (bcnt_r < CW'(MAX_BLOCKS)) bmem[bcnt_r[IW-1:0]] <= new_e;
      end else if (fcnt_r < CW'(MAX_BLOCKS)) fmem[fcnt_r[IW-1:0]] <= new_e;
    end
  end

  // sequencer: once a hit is found, DECIDE/SHIFT pairs compact the rest
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (start) state_nxt = (in_kind == KIND_ALLOC || in_kind == KIND_FREE)
                             ? S_SCAN : S_DONE;
      S_SCAN:   state_nxt = (idx_r < scnt) ? S_DECIDE : S_APPEND;
      S_DECIDE: state_nxt = (found_r || cmp.hit) ? S_SHIFT : S_SCAN;
      S_SHIFT:  state_nxt = ((idx_r + CW'(2)) < scnt) ? S_DECIDE : S_APPEND;
      S_APPEND: state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; base_r <= '0; psize_r <= '0; ovh_r <= 8'd16;
      top_r <= '0; left_r <= '0; bcnt_r <= '0; fcnt_r <= '0;
      out_valid <= 1'b0; found_r <= 1'b0; idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_POOL_BASE: base_r <= cfg_wdata;
          CFG_POOL_SIZE: psize_r <= cfg_wdata;
          CFG_OVERHEAD:  ovh_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: if (start) begin
          kind_r <= in_kind;
          need_r <= {1'b0, in_req_size} + 33'(ovh_r);
          key_r <= key_ext;
          idx_r <= '0; found_r <= 1'b0; stat_r <= ST_OK; baddr_r <= '0;
          if (in_kind == KIND_RESTART) begin
            bcnt_r <= '0; fcnt_r <= '0;
            top_r <= ADDR_BITS'(base_r); left_r <= psize_r;
          end
        end
        S_SCAN: ;
        S_DECIDE: if (!found_r) begin
          if (cmp.hit) begin
            found_r <= 1'b1; hit_r <= rd_r;
          end else idx_r <= idx_r + CW'(1);
        end
        S_SHIFT: idx_r <= idx_r + CW'(1);
        S_APPEND: begin
          if (src_free) begin
            if (found_r) begin
              fcnt_r <= fcnt_r - CW'(1);
              if (bcnt_r < CW'(MAX_BLOCKS)) bcnt_r <= bcnt_r + CW'(1);
              baddr_r <= 32'(hit_r[EW-1:33]);
            end else if ({1'b0, left_r} < need_r) stat_r <= ST_NOSPACE;
            else if ((bcnt_r + fcnt_r) >= CW'(MAX_BLOCKS)) stat_r <= ST_FULL;
            else begin
              bcnt_r <= bcnt_r + CW'(1);
              baddr_r <= 32'(top_r);
              top_r <= top_r + ADDR_BITS'(need_r);
              left_r <= left_r - need_r[31:0];
            end
          end else if (found_r) begin
            bcnt_r <= bcnt_r - CW'(1);
            if (fcnt_r < CW'(MAX_BLOCKS)) fcnt_r <= fcnt_r + CW'(1);
          end else stat_r <= ST_UNKNOWN;
        end
        S_DONE: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // hold off the state side so the out read sees final lists
  logic [1:0] st_o;
  assign st_o = (kind_r == KIND_ALLOC || kind_r == KIND_FREE) ? stat_r : ST_OK;
  assign busy = (state_r != S_IDLE);
  assign out_status = st_o;
  assign out_block_addr = (kind_r == KIND_ALLOC) ? baddr_r : 32'd0;
  assign out_any_busy = (bcnt_r != '0);
  assign out_oldest_busy_addr = (bcnt_r != '0) ? 32'(oldest_r) : 32'd0;

  // checks
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (bcnt_r + fcnt_r) <= CW'(MAX_BLOCKS)) else $error("list counts overflow");
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result strobe");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept without busy");
endmodule
`default_nettype wire

/* sim/pool_block_allocator_top_test.sv */
// Testbench: random and directed allocate/free/restart traffic against a scoreboard predictor.
`timescale 1ns / 1ps
module pool_block_allocator_top_test;
  import pba_pkg::*;

  localparam int NBLK      = 16;
  localparam int STALL_MAX = 3000;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] block_addr;
    logic        any_busy;
    logic [31:0] oldest;
  } alloc_result_t;

  typedef struct {
    logic [31:0] addr;
    logic [32:0] size;
  } blk_t;

  // Allocator predictor plus queue of expected results
  class alloc_scoreboard;
    logic [31:0]   base_r, size_r;
    logic [7:0]    ovh_r;
    blk_t          busy_q[$];
    blk_t          freed_q[$];
    logic [31:0]   top;
    logic [31:0]   left;
    alloc_result_t pending_q[$];
    int            errors;

    function new();
      base_r = 0; size_r = 0; ovh_r = 8'd16;
      top = 0; left = 0; errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] v);
      if (idx == CFG_POOL_BASE) base_r = v;
      else if (idx == CFG_POOL_SIZE) size_r = v;
      else if (idx == CFG_OVERHEAD) ovh_r = v[7:0];
    endfunction

    // Compute the result of one accepted beat and queue it
    function void note_input(logic [1:0] kind, logic [31:0] req, logic [31:0] faddr);
      alloc_result_t r;
      logic [32:0]   need;
      blk_t          b;
      int            hit;
      r.status = ST_OK;
      r.block_addr = 0;
      hit = -1;
      if (kind == KIND_ALLOC) begin
        need = {1'b0, req} + {25'd0, ovh_r};
        foreach (freed_q[i])
          if (hit < 0 && freed_q[i].size >= need) hit = i;
        if (hit >= 0) begin
          b = freed_q[hit];
          freed_q.delete(hit);
          busy_q = {busy_q, b};
          r.block_addr = b.addr;
        end else if ({1'b0, left} < need) begin
          r.status = ST_NOSPACE;
        end else if (busy_q.size() + freed_q.size() >= NBLK) begin
          r.status = ST_FULL;
        end else begin
          b.addr = top;
          b.size = need;
          busy_q = {busy_q, b};
          r.block_addr = top;
          top = top + need[31:0];
          left = left - need[31:0];
        end
      end else if (kind == KIND_FREE) begin
        foreach (busy_q[i])
          if (hit < 0 && busy_q[i].addr == faddr) hit = i;
        if (hit >= 0) begin
          b = busy_q[hit];
          busy_q.delete(hit);
          freed_q = {freed_q, b};
        end else begin
          r.status = ST_UNKNOWN;
        end
      end else if (kind == KIND_RESTART) begin
        busy_q.delete();
        freed_q.delete();
        top = base_r;
        left = size_r;
      end
      r.any_busy = busy_q.size() > 0;
      r.oldest = busy_q.size() > 0 ? busy_q[0].addr : 32'd0;
      pending_q = {pending_q, r};
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check_result(alloc_result_t got);
      alloc_result_t w;
      if (pending_q.size() == 0) begin
        report("unexpected beat", got.block_addr, 0);
        return;
      end
      w = pending_q.pop_front();
      if (got.status !== w.status) report("status", got.status, w.status);
      if (got.block_addr !== w.block_addr) report("block_addr", got.block_addr, w.block_addr);
      if (got.any_busy !== w.any_busy) report("any_busy", got.any_busy, w.any_busy);
      if (got.oldest !== w.oldest) report("oldest_busy_addr", got.oldest, w.oldest);
    endtask

    // A busy address to free, or a random one when nothing is allocated
    function logic [31:0] busy_pick();
      if (busy_q.size() == 0) return $urandom;
      return busy_q[$urandom_range(0, busy_q.size() - 1)].addr;
    endfunction
  endclass

  logic        clk, rst_n, start, busy;
  logic [1:0]  in_kind;
  logic [31:0] in_req_size, in_free_addr;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        out_valid, out_any_busy;
  logic [1:0]  out_status;
  logic [31:0] out_block_addr, out_oldest_busy_addr;

  alloc_scoreboard sb = new();
  bit  gaps_on;
  int  stall_cnt;

  pool_block_allocator_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_req_size(in_req_size), .in_free_addr(in_free_addr),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_status(out_status), .out_block_addr(out_block_addr),
    .out_any_busy(out_any_busy), .out_oldest_busy_addr(out_oldest_busy_addr)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // Accepted beats in, result beats out, stall watchdog
  always @(posedge clk) begin
    alloc_result_t got;
    if (rst_n) begin
      if (out_valid) begin
        got.status = out_status;
        got.block_addr = out_block_addr;
        got.any_busy = out_any_busy;
        got.oldest = out_oldest_busy_addr;
        sb.check_result(got);
      end
      if (start && !busy) sb.note_input(in_kind, in_req_size, in_free_addr);
      if (out_valid || (start && !busy)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_MAX) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task send(logic [1:0] kind, logic [31:0] req, logic [31:0] faddr);
    int gap;
    start <= 1'b1;
    in_kind <= kind;
    in_req_size <= req;
    in_free_addr <= faddr;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task cfg_write(logic [1:0] idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  task set_pool(logic [31:0] b, logic [31:0] s, logic [7:0] o);
    wait_idle();
    cfg_write(CFG_POOL_BASE, b);
    cfg_write(CFG_POOL_SIZE, s);
    cfg_write(CFG_OVERHEAD, {24'd0, o});
    send(KIND_RESTART, $urandom, $urandom);
  endtask

  // Random traffic: mostly small allocs and frees of live blocks
  task random_items(int n);
    int r;
    logic [31:0] req;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      req = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 64);
      if (r < 50) send(KIND_ALLOC, req, $urandom);
      else if (r < 85) send(KIND_FREE, $urandom, sb.busy_pick());
      else if (r < 92) send(KIND_FREE, $urandom, $urandom);
      else if (r < 96) send(KIND_RESTART, $urandom, $urandom);
      else send(2'd3, $urandom, $urandom);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = KIND_ALLOC;
    in_req_size = 0;
    in_free_addr = 0;
    cfg_we = 1'b0;
    cfg_index = CFG_POOL_BASE;
    cfg_wdata = 0;
    stall_cnt = 0;
    gaps_on = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty pool straight out of reset
    send(KIND_ALLOC, 32'd0, 32'd0);
    send(KIND_FREE, 32'd0, 32'd0);
    send(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Zero-sized blocks share an address; free takes the oldest
    set_pool(32'h0000_1000, 32'h0000_0100, 8'd0);
    send(KIND_ALLOC, 32'd0, 32'd0);
    send(KIND_ALLOC, 32'd0, 32'd0);
    send(KIND_FREE, 32'd0, 32'h0000_1000);
    send(KIND_ALLOC, 32'hFFFF_FFFF, 32'd0);
    // fill the table, then reuse freed blocks first fit
    for (int k = 0; k < 15; k++) send(KIND_ALLOC, 32'd8, 32'd0);
    send(KIND_FREE, 32'd0, 32'h0000_1008);
    send(KIND_ALLOC, 32'd4, 32'd0);
    send(KIND_ALLOC, 32'd9, 32'd0);

    // Max overhead, 33-bit need, address wrap
    set_pool(32'hFFFF_FFF0, 32'hFFFF_FFFF, 8'd255);
    send(KIND_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send(KIND_ALLOC, 32'h0000_0020, 32'd0);
    send(KIND_ALLOC, 32'h0000_0001, 32'd0);

    gaps_on = 1'b1;
    set_pool(32'h0000_4000, 32'h0000_0400, 8'd16);
    random_items(80);
    set_pool(32'h0000_0000, 32'h0000_0000, 8'd0);
    random_items(40);
    set_pool(32'hFFFF_FF00, 32'hFFFF_FFFF, 8'd255);
    random_items(80);
    gaps_on = 1'b0;
    set_pool($urandom, 32'h0000_0200, 8'd4);
    random_items(80);
    gaps_on = 1'b1;
    set_pool($urandom, $urandom, $urandom_range(0, 255));
    random_items(80);
    set_pool(32'h8000_0000, 32'h0000_0800, 8'd1);
    random_items(60);

    wait_idle();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
